### hdl/illl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// illl_pkg: shared types and constants of the linked-list engine
// Holds the command codes, the successor-table entry layout and the
// request, result and memory-access groups passed between modules.
// ----------------------------------------------------------------------------
package illl_pkg;

  // Item index width and successor-table depth.
  localparam int unsigned IdxW       = 8;
  localparam int unsigned TableDepth = 256;

  typedef logic [IdxW-1:0] idx_t;

  // Highest item that may join the list.
  localparam idx_t MaxItems = idx_t'(255);
  // Last address of the table, used by the clearing pass.
  localparam idx_t IdxLast  = idx_t'(TableDepth - 1);

  // Command codes.
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_GET    = 3'd5
  } cmd_e;

  // One successor-table entry: member flag and successor index.
  typedef struct packed {
    logic member;
    idx_t succ;
  } entry_t;

  // Fields of one input item.
  typedef struct packed {
    logic [2:0] cmd;
    idx_t       item;
    idx_t       after_item;
    idx_t       count;
    idx_t       position;
  } req_t;

  // Fields of one result item.
  typedef struct packed {
    idx_t found_item;
    idx_t head;
    idx_t tail;
    logic error;
  } res_t;

  // Table access issued by the sequencer in one cycle.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   ra_addr;
    idx_t   rb_addr;
  } mem_req_t;

endpackage

### hdl/illl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// illl_mem: successor table
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module illl_mem (
  input  logic              clk_i,
  input  illl_pkg::mem_req_t req_i,
  output illl_pkg::entry_t  rd_a_o,
  output illl_pkg::entry_t  rd_b_o
);
  import illl_pkg::*;

  entry_t mem_q [TableDepth];
  entry_t rd_a_q;
  entry_t rd_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[req_i.ra_addr];
    rd_b_q <= mem_q[req_i.rb_addr];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

### hdl/illl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// illl_ctrl: command sequencer of the linked-list engine
// Keeps head and tail, issues table reads and writes, walks the list for
// remove, clear and get, and runs the clearing pass after reset.
// ----------------------------------------------------------------------------
module illl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  illl_pkg::req_t     req_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output illl_pkg::res_t     res_o,
  output illl_pkg::mem_req_t mem_o,
  input  illl_pkg::entry_t   rd_a_i,
  input  illl_pkg::entry_t   rd_b_i
);
  import illl_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_REM  = 3'd4;
  localparam logic [2:0] S_GET  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  idx_t       init_q, init_d;
  idx_t       head_q, head_d;
  idx_t       tail_q, tail_d;
  cmd_e       cmd_q, cmd_d;
  idx_t       item_q, item_d;
  idx_t       anc_q, anc_d;
  idx_t       left_q, left_d;
  idx_t       link_q, link_d;
  idx_t       found_q, found_d;
  logic       err_q, err_d;
  logic       addable;
  cmd_e       in_cmd;

  assign in_cmd  = cmd_e'(req_i.cmd);
  // The item may join the list: not null, in range and not yet a member.
  assign addable = (item_q != '0) && (item_q <= MaxItems) && !rd_a_i.member;

  // Next-state and table-access logic.
  always_comb begin
    state_d        = state_q;
    init_d         = init_q;
    head_d         = head_q;
    tail_d         = tail_q;
    cmd_d          = cmd_q;
    item_d         = item_q;
    anc_d          = anc_q;
    left_d         = left_q;
    link_d         = link_q;
    found_d        = found_q;
    err_d          = err_q;
    in_ready_o     = 1'b0;
    res_valid_o    = 1'b0;
    mem_o          = '0;
    mem_o.waddr    = item_q;
    mem_o.ra_addr  = req_i.item;
    mem_o.rb_addr  = (in_cmd == CMD_INSERT) ? req_i.after_item : head_q;

    unique case (state_q)
      // Clear every table entry after reset.
      S_INIT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = init_q;
        mem_o.wdata = '0;
        init_d      = init_q + idx_t'(1);
        if (init_q == IdxLast) begin
          state_d = S_IDLE;
        end
      end

      // Take an item; the table reads for it are issued in this cycle.
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = in_cmd;
          item_d  = req_i.item;
          anc_d   = req_i.after_item;
          left_d  = req_i.count;
          found_d = '0;
          err_d   = 1'b0;
          unique case (in_cmd)
            CMD_PUSH, CMD_INSERT: begin
              state_d = (req_i.item == '0) ? S_DONE : S_CHK;
            end
            CMD_APPEND: begin
              state_d = S_CHK;
            end
            CMD_REMOVE: begin
              state_d = (req_i.count == '0 || head_q == '0) ? S_DONE : S_REM;
            end
            CMD_CLEAR: begin
              state_d = (head_q == '0) ? S_DONE : S_REM;
            end
            CMD_GET: begin
              left_d = req_i.position - idx_t'(1);
              if (req_i.position == '0 || head_q == '0) begin
                state_d = S_DONE;
              end else if (req_i.position == idx_t'(1)) begin
                found_d = head_q;
                state_d = S_DONE;
              end else begin
                state_d = S_GET;
              end
            end
            default: begin
              err_d   = 1'b1;
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Check membership and write the new item's entry.
      S_CHK: begin
        state_d = S_DONE;
        if (cmd_q == CMD_APPEND) begin
          if (!addable) begin
            err_d = 1'b1;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.wdata = '{member: 1'b1, succ: '0};
            tail_d      = item_q;
            if (head_q == '0) begin
              head_d = item_q;
            end else begin
              link_d  = tail_q;
              state_d = S_LINK;
            end
          end
        end else if (cmd_q == CMD_INSERT && anc_q != '0) begin
          if (!addable || !rd_b_i.member) begin
            err_d = 1'b1;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.wdata = '{member: 1'b1, succ: rd_b_i.succ};
            link_d      = anc_q;
            state_d     = S_LINK;
            if (tail_q == anc_q) begin
              tail_d = item_q;
            end
          end
        end else begin
          // Push to the front, also insert after the null item.
          if (!addable) begin
            err_d = 1'b1;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.wdata = '{member: 1'b1, succ: head_q};
            head_d      = item_q;
            if (head_q == '0) begin
              tail_d = item_q;
            end
          end
        end
      end

      // Point the predecessor at the new item.
      S_LINK: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = link_q;
        mem_o.wdata = '{member: 1'b1, succ: item_q};
        state_d     = S_DONE;
      end

      // Drop the front item, one per cycle.
      S_REM: begin
        mem_o.we      = 1'b1;
        mem_o.waddr   = head_q;
        mem_o.wdata   = '0;
        mem_o.rb_addr = rd_b_i.succ;
        head_d        = rd_b_i.succ;
        left_d        = left_q - idx_t'(1);
        if (rd_b_i.succ == '0) begin
          tail_d  = '0;
          state_d = S_DONE;
        end else if (cmd_q != CMD_CLEAR && left_q == idx_t'(1)) begin
          state_d = S_DONE;
        end
      end

      // Follow successors until the position is reached or the list ends.
      S_GET: begin
        mem_o.rb_addr = rd_b_i.succ;
        left_d        = left_q - idx_t'(1);
        if (rd_b_i.succ == '0 || left_q == idx_t'(1)) begin
          found_d = rd_b_i.succ;
          state_d = S_DONE;
        end
      end

      // Hand the result to the output register.
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  // Per-command working registers.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    item_q  <= item_d;
    anc_q   <= anc_d;
    left_q  <= left_d;
    link_q  <= link_d;
    found_q <= found_d;
    err_q   <= err_d;
  end

  assign res_o = '{found_item: found_q, head: head_q, tail: tail_q, error: err_q};

endmodule

### hdl/indexed_linked_list_engine.sv
`timescale 1ns / 1ps
// Unknown commands, null push or insert, get of position 0 or 1 and remove or
// clear with nothing to drop go straight to the result; push, front insert,
// append to an empty list and rejected adds pass the check; append and insert
// after a member also link the predecessor; remove, clear and get walk the list.
// One item at a time: the next is taken once the last result is handed on.
// Reset: head and tail clear at once; a pass clearing all 256 entries follows.
// ----------------------------------------------------------------------------
// indexed_linked_list_engine: array-backed singly linked list
// Successor table in a synchronous memory, a command sequencer and an
// output register for the result items.
// ----------------------------------------------------------------------------
module indexed_linked_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // item [7:0], after_item [15:8], count [23:16], position [31:24]
  input  logic [31:0] s_axis_tdata,
  // cmd [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // found_item [7:0], head [15:8], tail [23:16]
  output logic [23:0] m_axis_tdata,
  // error [0]
  output logic [0:0]  m_axis_tuser
);
  import illl_pkg::*;

  req_t     req;
  res_t     res;
  mem_req_t mem_req;
  entry_t   rd_a;
  entry_t   rd_b;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_q;
  res_t     out_q;

  // Unpack the input item.
  assign req = '{cmd:        s_axis_tuser,
                 item:       s_axis_tdata[7:0],
                 after_item: s_axis_tdata[15:8],
                 count:      s_axis_tdata[23:16],
                 position:   s_axis_tdata[31:24]};

  illl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem_req),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b)
  );

  illl_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // Output register: loads when empty or being emptied.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.tail, out_q.head, out_q.found_item};
  assign m_axis_tuser  = out_q.error;

endmodule

### hdl/illl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// illl_checker: port-level checks of the linked-list engine
// Watches the stream ports and flags results and handshakes that break
// the list's rules.
// ----------------------------------------------------------------------------
module illl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result item changed");

  // Head and tail are empty together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[15:8] == 8'd0) == (m_axis_tdata[23:16] == 8'd0)))
    else $error("head and tail disagree on an empty list");

  // A failed command reports no found item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("error result carries a found item");

  // Items are worked one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

endmodule

bind indexed_linked_list_engine illl_checker u_illl_checker (.*);

### bench/tb_indexed_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_linked_list_engine: self-checking bench for the linked-list engine
// Drives commands on the input stream and keeps its own copy of the list:
// member flags, successor indexes, head, tail and length. Each accepted
// command yields one expected result, which is compared field by field with
// the next result item on the output stream. Directed corner cases come
// first, then back-pressure, then long runs of random list traffic and noise.
// ----------------------------------------------------------------------------
module tb_indexed_linked_list_engine;
  import illl_pkg::*;

  // Codes outside the command set, which the block must reject.
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  localparam int IdlePercent = 11;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 300;
  localparam int MaxPrinted  = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // item [7:0], after_item [15:8], count [23:16], position [31:24]
  logic [31:0] s_axis_tdata;
  // cmd [2:0]
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // found_item [7:0], head [15:8], tail [23:16]
  logic [23:0] m_axis_tdata;
  // error [0]
  logic [0:0]  m_axis_tuser;

  indexed_linked_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the list kept by the bench.
  logic member_flag [TableDepth];
  idx_t next_of     [TableDepth];
  idx_t list_head;
  idx_t list_tail;
  int   list_len;
  int   longest_list;

  res_t expected_results [$];
  int   mismatch_count;
  int   items_sent;
  int   results_seen;
  int   error_results;
  bit   quiet_mode;
  bit   hold_request;
  int   stall_cycles;

  // Report one mismatch; only the first few are printed.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("[%0t] mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic bit can_join(input idx_t x);
    return x != 0 && x <= MaxItems && !member_flag[x];
  endfunction

  function automatic void put_in_front(input idx_t x);
    if (list_head == 0) list_tail = x;
    member_flag[x] = 1'b1;
    next_of[x]     = list_head;
    list_head      = x;
    list_len++;
  endfunction

  // Apply one command to the shadow list and return the result it gives.
  function automatic res_t apply_command(input logic [2:0] op, input idx_t it,
                                         input idx_t anc, input idx_t cnt,
                                         input idx_t pos);
    res_t r;
    idx_t cur;
    idx_t front;
    int   n;
    r = '0;
    case (op)
      CMD_PUSH: begin
        if (it != 0) begin
          if (can_join(it)) put_in_front(it);
          else r.error = 1'b1;
        end
      end
      CMD_APPEND: begin
        if (!can_join(it)) begin
          r.error = 1'b1;
        end else begin
          if (list_head == 0) list_head = it;
          else next_of[list_tail] = it;
          member_flag[it] = 1'b1;
          next_of[it]     = '0;
          list_tail       = it;
          list_len++;
        end
      end
      CMD_INSERT: begin
        if (it != 0) begin
          if (!can_join(it) || (anc != 0 && !member_flag[anc])) begin
            r.error = 1'b1;
          end else if (anc == 0) begin
            put_in_front(it);
          end else begin
            member_flag[it] = 1'b1;
            next_of[it]     = next_of[anc];
            next_of[anc]    = it;
            if (list_tail == anc) list_tail = it;
            list_len++;
          end
        end
      end
      CMD_REMOVE: begin
        for (n = 0; n < cnt && list_head != 0; n++) begin
          front              = list_head;
          list_head          = next_of[front];
          member_flag[front] = 1'b0;
          next_of[front]     = '0;
          list_len--;
        end
        if (list_head == 0) list_tail = '0;
      end
      CMD_CLEAR: begin
        for (n = 0; n < TableDepth; n++) begin
          member_flag[n] = 1'b0;
          next_of[n]     = '0;
        end
        list_head = '0;
        list_tail = '0;
        list_len  = 0;
      end
      CMD_GET: begin
        if (pos != 0) begin
          cur = list_head;
          for (n = 1; n < pos && cur != 0; n++) cur = next_of[cur];
          r.found_item = cur;
        end
      end
      default: begin
        r.error = 1'b1;
      end
    endcase
    r.head = list_head;
    r.tail = list_tail;
    if (list_len > longest_list) longest_list = list_len;
    return r;
  endfunction

  // Offer one item, wait for its handshake and record the expected result.
  task automatic send_item(input logic [2:0] op, input idx_t it, input idx_t anc,
                           input idx_t cnt, input idx_t pos);
    while (!quiet_mode && $urandom_range(99) < IdlePercent) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tdata  = {pos, cnt, anc, it};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(apply_command(op, it, anc, cnt, pos));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // A random item that is not in the list, or any item once the list is full.
  function automatic idx_t pick_free_item();
    idx_t x;
    x = idx_t'($urandom_range(1, MaxItems));
    if (list_len >= MaxItems) return x;
    while (member_flag[x]) x = idx_t'($urandom_range(1, MaxItems));
    return x;
  endfunction

  function automatic idx_t pick_member();
    idx_t x;
    if (list_len == 0) return '0;
    x = idx_t'($urandom_range(1, MaxItems));
    while (!member_flag[x]) x = idx_t'($urandom_range(1, MaxItems));
    return x;
  endfunction

  // Corner cases: empty list, null item, duplicates, anchors, walks past the end.
  task automatic test_directed();
    send_item(CMD_GET,    8'd0,   8'd0,   8'd0,   8'd1);
    send_item(CMD_CLEAR,  8'd0,   8'd0,   8'd0,   8'd0);
    send_item(CMD_REMOVE, 8'd0,   8'd0,   8'd5,   8'd0);
    send_item(CMD_PUSH,   8'd0,   8'd0,   8'd0,   8'd0);
    send_item(CMD_APPEND, 8'd0,   8'd0,   8'd0,   8'd0);
    send_item(CMD_INSERT, 8'd0,   8'd77,  8'd0,   8'd0);
    send_item(CMD_PUSH,   8'd255, 8'd0,   8'd0,   8'd0);
    send_item(CMD_PUSH,   8'd255, 8'd0,   8'd0,   8'd0);
    send_item(CMD_APPEND, 8'd1,   8'd0,   8'd0,   8'd0);
    send_item(CMD_INSERT, 8'd128, 8'd0,   8'd0,   8'd0);
    send_item(CMD_INSERT, 8'd7,   8'd99,  8'd0,   8'd0);
    send_item(CMD_INSERT, 8'd200, 8'd1,   8'd0,   8'd0);
    send_item(CMD_INSERT, 8'd5,   8'd255, 8'd0,   8'd0);
    send_item(CMD_APPEND, 8'd255, 8'd0,   8'd0,   8'd0);
    send_item(CMD_INSERT, 8'd1,   8'd128, 8'd0,   8'd0);
    send_item(CMD_GET,    8'd0,   8'd0,   8'd0,   8'd0);
    send_item(CMD_GET,    8'd0,   8'd0,   8'd0,   8'd5);
    send_item(CMD_GET,    8'd0,   8'd0,   8'd0,   8'd6);
    send_item(CMD_GET,    8'd0,   8'd0,   8'd0,   8'd255);
    send_item(CmdSpare6,  8'd3,   8'd0,   8'd0,   8'd0);
    send_item(CmdSpare7,  8'd255, 8'd255, 8'd255, 8'd255);
    send_item(CMD_REMOVE, 8'd0,   8'd0,   8'd0,   8'd0);
    send_item(CMD_REMOVE, 8'd0,   8'd0,   8'd2,   8'd0);
    send_item(CMD_REMOVE, 8'd0,   8'd0,   8'd255, 8'd0);
    send_item(CMD_APPEND, 8'd3,   8'd0,   8'd0,   8'd0);
    wait_results_drained();
  endtask

  // The receiver stalls for a long stretch while items keep coming.
  task automatic test_backpressure();
    int i;
    hold_request = 1'b1;
    for (i = 0; i < 12; i++) send_item(CMD_PUSH, pick_free_item(), 8'd0, 8'd0, 8'd0);
    wait_results_drained();
  endtask

  // Mostly well-formed list traffic with random content.
  task automatic test_random_lists(input int n);
    int   i;
    int   r;
    idx_t anc;
    idx_t cnt;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 26) begin
        send_item(CMD_PUSH, pick_free_item(), 8'd0, 8'd0, 8'd0);
      end else if (r < 46) begin
        send_item(CMD_APPEND, pick_free_item(), 8'd0, 8'd0, 8'd0);
      end else if (r < 64) begin
        // Mostly a real anchor, sometimes the front or a random one.
        case ($urandom_range(9))
          0:       anc = '0;
          1:       anc = idx_t'($urandom_range(255));
          default: anc = pick_member();
        endcase
        send_item(CMD_INSERT, pick_free_item(), anc, 8'd0, 8'd0);
      end else if (r < 78) begin
        send_item(CMD_GET, 8'd0, 8'd0, 8'd0,
                  ($urandom_range(19) == 0) ? idx_t'($urandom_range(255))
                                            : idx_t'($urandom_range(1, list_len + 2)));
      end else if (r < 95) begin
        if ($urandom_range(19) == 0) cnt = idx_t'($urandom_range(255));
        else if (list_len > 180) cnt = idx_t'($urandom_range(60));
        else cnt = idx_t'($urandom_range(4));
        send_item(CMD_REMOVE, 8'd0, 8'd0, cnt, 8'd0);
      end else if (r < 97) begin
        send_item(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
      end else begin
        send_item(3'($urandom_range(7)), idx_t'($urandom), idx_t'($urandom),
                  idx_t'($urandom), idx_t'($urandom));
      end
    end
  endtask

  // Fully random fields, unknown commands included.
  task automatic test_random_noise(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_item(3'($urandom_range(7)), idx_t'($urandom), idx_t'($urandom),
                idx_t'($urandom), idx_t'($urandom));
  endtask

  // A stretch where neither side idles.
  task automatic test_no_idling(input int n);
    quiet_mode = 1'b1;
    test_random_lists(n);
    wait_results_drained();
    quiet_mode = 1'b0;
  endtask

  // Receiver: random stalls, a long hold on request, none in quiet stretches.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        m_axis_tready = quiet_mode || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser[0]) error_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(m_axis_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[7:0] !== want.found_item)
          report_mismatch("found_item", 32'(m_axis_tdata[7:0]), 32'(want.found_item));
        if (m_axis_tdata[15:8] !== want.head)
          report_mismatch("head", 32'(m_axis_tdata[15:8]), 32'(want.head));
        if (m_axis_tdata[23:16] !== want.tail)
          report_mismatch("tail", 32'(m_axis_tdata[23:16]), 32'(want.tail));
        if (m_axis_tuser[0] !== want.error)
          report_mismatch("error", 32'(m_axis_tuser[0]), 32'(want.error));
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < TableDepth; i++) begin
      member_flag[i] = 1'b0;
      next_of[i]     = '0;
    end
    list_head      = '0;
    list_tail      = '0;
    list_len       = 0;
    longest_list   = 0;
    mismatch_count = 0;
    items_sent     = 0;
    results_seen   = 0;
    error_results  = 0;
    quiet_mode     = 1'b0;
    hold_request   = 1'b0;
    stall_cycles   = 0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    rst_ni         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_random_lists(700);
    test_no_idling(300);
    test_random_noise(200);
    test_random_lists(700);

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d commands and %0d results, %0d of them errors",
             items_sent, results_seen, error_results);
    $display("longest list reached %0d items; %0d mismatches", longest_list,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
